### design/assert_macros.svh
// Assertion macros used by the token class lexer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition is never true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### design/tcl_pkg.sv
// Types, result codes and match tables of the token class lexer.
package tcl_pkg;

   localparam int KW_COUNT = 16;
   localparam int OP_COUNT = 11;

   localparam logic [2:0] KIND_RESERVED = 3'd0;
   localparam logic [2:0] KIND_INTEGER  = 3'd1;
   localparam logic [2:0] KIND_FLOAT    = 3'd2;
   localparam logic [2:0] KIND_OPERATOR = 3'd3;
   localparam logic [2:0] KIND_VARIABLE = 3'd4;
   localparam logic [2:0] KIND_LINE_END = 3'd5;
   localparam logic [2:0] KIND_ERROR    = 3'd6;
   localparam logic [2:0] KIND_ACCEPTED = 3'd7;

   localparam logic [7:0] SEMI_CHAR  = 8'h3B;
   localparam logic [7:0] DOT_CHAR   = 8'h2E;
   localparam logic [7:0] UNDER_CHAR = 8'h5F;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] NUL_CHAR   = 8'h00;

   localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
      '{"c", "o", "n", "s", "t", NUL_CHAR, NUL_CHAR, NUL_CHAR},
      '{"i", "n", "t", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
      '{"f", "l", "o", "a", "t", NUL_CHAR, NUL_CHAR, NUL_CHAR},
      '{"d", "o", "u", "b", "l", "e", NUL_CHAR, NUL_CHAR},
      '{"l", "o", "n", "g", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
      '{"s", "t", "a", "t", "i", "c", NUL_CHAR, NUL_CHAR},
      '{"v", "o", "i", "d", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
      '{"c", "h", "a", "r", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
      '{"e", "x", "t", "e", "r", "n", NUL_CHAR, NUL_CHAR},
      '{"r", "e", "t", "u", "r", "n", NUL_CHAR, NUL_CHAR},
      '{"b", "r", "e", "a", "k", NUL_CHAR, NUL_CHAR, NUL_CHAR},
      '{"e", "n", "u", "m", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR},
      '{"s", "t", "r", "u", "c", "t", NUL_CHAR, NUL_CHAR},
      '{"t", "y", "p", "e", "d", "e", "f", NUL_CHAR},
      '{"u", "n", "i", "o", "n", NUL_CHAR, NUL_CHAR, NUL_CHAR},
      '{"g", "o", "t", "o", NUL_CHAR, NUL_CHAR, NUL_CHAR, NUL_CHAR}
   };

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd5, 4'd3, 4'd5, 4'd6, 4'd4, 4'd6, 4'd4, 4'd4,
      4'd6, 4'd6, 4'd5, 4'd4, 4'd6, 4'd7, 4'd5, 4'd4
   };

   localparam logic [7:0] OP_TEXT [OP_COUNT][2] = '{
      '{"+", NUL_CHAR}, '{"-", NUL_CHAR}, '{"*", NUL_CHAR}, '{"/", NUL_CHAR},
      '{"=", NUL_CHAR}, '{"=", "="}, '{"!", "="}, '{">", "="}, '{"<", "="},
      '{">", NUL_CHAR}, '{"<", NUL_CHAR}
   };

   localparam logic [3:0] OP_LEN [OP_COUNT] = '{
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd1, 4'd1
   };

   typedef struct packed {
      logic [7:0] ch;
      logic       is_end;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic       two;
      logic [2:0] kind_a;
      logic [2:0] kind_b;
   } tcl_item_type;

endpackage

### design/tcl_scan.sv
// Lexer state and the per-byte token classification.
module tcl_scan
   import tcl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_type      req,
   output tcl_item_type item
);

   logic [KW_COUNT-1:0] keyword_live_ff, keyword_live_in;
   logic [OP_COUNT-1:0] operator_live_ff, operator_live_in;
   logic [3:0]          token_length_ff, token_length_in;
   logic                all_digits_ff, all_digits_in;
   logic                float_shape_ok_ff, float_shape_ok_in;
   logic                dot_seen_ff, dot_seen_in;
   logic                ident_chars_ok_ff, ident_chars_ok_in;
   logic                starts_with_digit_ff, starts_with_digit_in;
   logic                error_latched_ff, error_latched_in;
   logic                ends_with_semicolon_ff, ends_with_semicolon_in;

   logic       is_digit, is_alpha, is_space, is_semi, is_dot, is_under;
   logic       tok_empty, kw_hit, op_hit, close_err, err_after;
   logic [2:0] close_kind, verdict;

   assign is_digit = (req.ch >= "0") && (req.ch <= "9");
   assign is_alpha = ((req.ch >= "a") && (req.ch <= "z")) ||
                     ((req.ch >= "A") && (req.ch <= "Z"));
   assign is_space = (req.ch == SPACE_CHAR) || ((req.ch >= 8'h09) && (req.ch <= 8'h0D));
   assign is_semi  = req.ch == SEMI_CHAR;
   assign is_dot   = req.ch == DOT_CHAR;
   assign is_under = req.ch == UNDER_CHAR;

   always_comb begin
      kw_hit = 1'b0;
      for (int i = 0; i < KW_COUNT; i++) begin
         kw_hit = kw_hit | (keyword_live_ff[i] & (token_length_ff == KW_LEN[i]));
      end
      op_hit = 1'b0;
      for (int i = 0; i < OP_COUNT; i++) begin
         op_hit = op_hit | (operator_live_ff[i] & (token_length_ff == OP_LEN[i]));
      end
   end

   always_comb begin
      tok_empty = token_length_ff == 4'd0;
      if (kw_hit) begin
         close_kind = KIND_RESERVED;
      end else if (all_digits_ff) begin
         close_kind = KIND_INTEGER;
      end else if (float_shape_ok_ff && dot_seen_ff && (token_length_ff > 4'd1)) begin
         close_kind = KIND_FLOAT;
      end else if (op_hit) begin
         close_kind = KIND_OPERATOR;
      end else if (ident_chars_ok_ff && !starts_with_digit_ff) begin
         close_kind = KIND_VARIABLE;
      end else begin
         close_kind = KIND_ERROR;
      end
      close_err = !tok_empty && (close_kind == KIND_ERROR);
      err_after = error_latched_ff | close_err;
      verdict   = (err_after || !ends_with_semicolon_ff) ? KIND_ERROR : KIND_ACCEPTED;
   end

   always_comb begin
      item = '0;
      if (req.is_end) begin
         item.valid = 1'b1;
         if (!error_latched_ff && !tok_empty) begin
            item.two    = 1'b1;
            item.kind_a = close_kind;
            item.kind_b = verdict;
         end else begin
            item.kind_a = verdict;
         end
      end else if (error_latched_ff) begin
         item = '0;
      end else if (is_space) begin
         item.valid  = !tok_empty;
         item.kind_a = close_kind;
      end else if (is_semi) begin
         item.valid = 1'b1;
         if (!tok_empty) begin
            item.kind_a = close_kind;
            item.two    = !close_err;
            item.kind_b = KIND_LINE_END;
         end else begin
            item.kind_a = KIND_LINE_END;
         end
      end
   end

   always_comb begin
      keyword_live_in        = keyword_live_ff;
      operator_live_in       = operator_live_ff;
      token_length_in        = token_length_ff;
      all_digits_in          = all_digits_ff;
      float_shape_ok_in      = float_shape_ok_ff;
      dot_seen_in            = dot_seen_ff;
      ident_chars_ok_in      = ident_chars_ok_ff;
      starts_with_digit_in   = starts_with_digit_ff;
      error_latched_in       = error_latched_ff;
      ends_with_semicolon_in = ends_with_semicolon_ff;
      if (req.is_end || (!error_latched_ff && (is_space || is_semi))) begin
         keyword_live_in      = '1;
         operator_live_in     = '1;
         token_length_in      = 4'd0;
         all_digits_in        = 1'b1;
         float_shape_ok_in    = 1'b1;
         dot_seen_in          = 1'b0;
         ident_chars_ok_in    = 1'b1;
         starts_with_digit_in = 1'b0;
         if (req.is_end) begin
            error_latched_in       = 1'b0;
            ends_with_semicolon_in = 1'b0;
         end else begin
            error_latched_in = err_after;
            if (is_semi) begin
               ends_with_semicolon_in = 1'b1;
            end
         end
      end else if (!error_latched_ff) begin
         ends_with_semicolon_in = 1'b0;
         for (int i = 0; i < KW_COUNT; i++) begin
            keyword_live_in[i] = keyword_live_ff[i] & (token_length_ff < KW_LEN[i]) &
                                 (KW_TEXT[i][token_length_ff[2:0]] == req.ch);
         end
         for (int i = 0; i < OP_COUNT; i++) begin
            operator_live_in[i] = operator_live_ff[i] & (token_length_ff < OP_LEN[i]) &
                                  (OP_TEXT[i][token_length_ff[0]] == req.ch);
         end
         all_digits_in = all_digits_ff & is_digit;
         if (is_dot) begin
            float_shape_ok_in = float_shape_ok_ff & !dot_seen_ff;
            dot_seen_in       = 1'b1;
         end else if (!is_digit) begin
            float_shape_ok_in = 1'b0;
         end
         ident_chars_ok_in = ident_chars_ok_ff & (is_alpha | is_digit | is_under);
         if (tok_empty) begin
            starts_with_digit_in = is_digit;
         end
         if (token_length_ff != 4'd15) begin
            token_length_in = token_length_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keyword_live_ff        <= '1;
         operator_live_ff       <= '1;
         token_length_ff        <= 4'd0;
         all_digits_ff          <= 1'b1;
         float_shape_ok_ff      <= 1'b1;
         dot_seen_ff            <= 1'b0;
         ident_chars_ok_ff      <= 1'b1;
         starts_with_digit_ff   <= 1'b0;
         error_latched_ff       <= 1'b0;
         ends_with_semicolon_ff <= 1'b0;
      end else if (fire) begin
         keyword_live_ff        <= keyword_live_in;
         operator_live_ff       <= operator_live_in;
         token_length_ff        <= token_length_in;
         all_digits_ff          <= all_digits_in;
         float_shape_ok_ff      <= float_shape_ok_in;
         dot_seen_ff            <= dot_seen_in;
         ident_chars_ok_ff      <= ident_chars_ok_in;
         starts_with_digit_ff   <= starts_with_digit_in;
         error_latched_ff       <= error_latched_in;
         ends_with_semicolon_ff <= ends_with_semicolon_in;
      end
   end

endmodule

### design/token_class_lexer.sv
// Top level of the token class lexer: input register, scanner and result queue.
// Each result passes the input register and then the result queue before it is offered.
// Throughput: one byte per cycle while the queue has room; paired results go out in turn.
// The two-entry result queue lets bytes keep flowing while a result waits to be taken.
// Reset is synchronous and active high; it empties the queue and clears the lexer state.
`include "assert_macros.svh"

module token_class_lexer
   import tcl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic         in_valid_ff, in_valid_in;
   req_type      in_data_ff;
   tcl_item_type queue_ff [2];
   logic [1:0]   q_count_ff, q_count_in;
   logic         q_head_ff, q_head_in;
   logic         sub_ff, sub_in;

   tcl_item_type item, head;
   logic         fire, push, pop, rsp_take, tail;

   tcl_scan u_scan (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (in_data_ff),
      .item  (item)
   );

   assign head          = queue_ff[q_head_ff];
   assign rsp_valid     = q_count_ff != 2'd0;
   assign rsp_data.kind = sub_ff ? head.kind_b : head.kind_a;
   assign rsp_data.last = head.two ? sub_ff : 1'b1;
   assign rsp_take      = rsp_valid && !rsp_stall;
   assign pop           = rsp_take && (!head.two || sub_ff);
   assign fire          = in_valid_ff && ((q_count_ff != 2'd2) || pop);
   assign push          = fire && item.valid;
   assign tail          = q_head_ff ^ q_count_ff[0];
   assign req_stall     = in_valid_ff && !fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      q_count_in = q_count_ff + {1'b0, push} - {1'b0, pop};
      q_head_in  = q_head_ff ^ pop;
      sub_in     = sub_ff;
      if (rsp_take) begin
         sub_in = head.two && !sub_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         q_count_ff  <= 2'd0;
         q_head_ff   <= 1'b0;
         sub_ff      <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         q_count_ff  <= q_count_in;
         q_head_ff   <= q_head_in;
         sub_ff      <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (push) begin
         queue_ff[tail] <= item;
      end
   end

   `ASSERT_NEVER(a_queue_bound, clock, reset, q_count_ff == 2'd3, "result queue overflow")
   `ASSERT_CLK(a_sub_two, clock, reset, sub_ff |-> (rsp_valid && head.two), "second half without pair")
   `ASSERT_CLK(a_stall_full, clock, reset, req_stall |-> (q_count_ff == 2'd2), "stall with queue room")
   `ASSERT_CLK(a_pair_follows, clock, reset, (rsp_take && !rsp_data.last) |=> rsp_valid, "pair split")

endmodule
